// ----- hw/rtl/mhi_pkg.sv -----
package mhi_pkg;

   localparam int CAPACITY     = 1024;
   localparam int SLOT_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 16;
   localparam int STATUS_BITS  = 2;

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_INSERTED   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL       = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_READ_OK    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_READ_EMPTY = 2'd3;

   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [PAYLOAD_BITS-1:0]    payload;
   } mhi_entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      mhi_entry_type        wr_data;
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
   } mhi_ram_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]     status;
      logic [SLOT_BITS-1:0]       where_placed;
      logic [COUNT_BITS-1:0]      entry_total;
      logic signed [KEY_BITS-1:0] read_key;
      logic [PAYLOAD_BITS-1:0]    read_payload;
   } mhi_result_type;

   function automatic logic [SLOT_BITS-1:0] parent_of(input logic [SLOT_BITS-1:0] pos);
      logic [SLOT_BITS-1:0] less_one;
      less_one = pos - SLOT_BITS'(1);
      return less_one >> 1;
   endfunction

endpackage

// ----- hw/rtl/mhi_entry_ram.sv -----
module mhi_entry_ram
   import mhi_pkg::*;
(
   input  logic            clock,
   input  mhi_ram_req_type ram_req,
   output mhi_entry_type   rd_data
);

   mhi_entry_type mem [CAPACITY];
   mhi_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mhi_sift_ctrl.sv -----
module mhi_sift_ctrl
   import mhi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic signed [KEY_BITS-1:0] req_key,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic [SLOT_BITS-1:0]    req_slot,
   output mhi_ram_req_type         ram_req,
   input  mhi_entry_type           rd_data,
   output logic                    res_valid,
   input  logic                    res_take,
   output mhi_result_type          result
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_SIFT       = 3'd1;
   localparam logic [2:0] S_PLACE_ROOT = 3'd2;
   localparam logic [2:0] S_READ_WAIT  = 3'd3;
   localparam logic [2:0] S_DONE       = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SLOT_BITS-1:0]  pos_ff, pos_in;
   mhi_entry_type         item_ff, item_in;
   mhi_result_type        res_ff, res_in;
   logic [SLOT_BITS-1:0]  up_pos;

   assign up_pos = parent_of(pos_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      item_in   = item_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      ram_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in.read_key     = '0;
               res_in.read_payload = '0;
               if (req_type == REQ_INSERT) begin
                  if (count_ff == FULL_COUNT) begin
                     res_in.status       = ST_FULL;
                     res_in.where_placed = '0;
                     res_in.entry_total  = count_ff;
                     state_in            = S_DONE;
                  end else begin
                     item_in.key     = req_key;
                     item_in.payload = req_payload;
                     count_in        = count_ff + COUNT_BITS'(1);
                     if (count_ff == '0) begin
                        // Empty heap: the item lands at the root directly.
                        ram_req.wr_en       = 1'b1;
                        ram_req.wr_addr     = '0;
                        ram_req.wr_data     = item_in;
                        res_in.status       = ST_INSERTED;
                        res_in.where_placed = '0;
                        res_in.entry_total  = count_in;
                        state_in            = S_DONE;
                     end else begin
                        pos_in          = count_ff[SLOT_BITS-1:0];
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = parent_of(pos_in);
                        state_in        = S_SIFT;
                     end
                  end
               end else begin
                  res_in.where_placed = req_slot;
                  res_in.entry_total  = count_ff;
                  if ({1'b0, req_slot} < count_ff) begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = req_slot;
                     state_in        = S_READ_WAIT;
                  end else begin
                     res_in.status = ST_READ_EMPTY;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_SIFT: begin
            // The parent of pos is on the read port. A larger item pulls the
            // parent down one level and the next parent is fetched at once;
            // the write and the read never address the same slot.
            if (item_ff.key > rd_data.key) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = pos_ff;
               ram_req.wr_data = rd_data;
               pos_in          = up_pos;
               if (up_pos == '0) begin
                  state_in = S_PLACE_ROOT;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = parent_of(up_pos);
               end
            end else begin
               ram_req.wr_en       = 1'b1;
               ram_req.wr_addr     = pos_ff;
               ram_req.wr_data     = item_ff;
               res_in.status       = ST_INSERTED;
               res_in.where_placed = pos_ff;
               res_in.entry_total  = count_ff;
               state_in            = S_DONE;
            end
         end
         S_PLACE_ROOT: begin
            ram_req.wr_en       = 1'b1;
            ram_req.wr_addr     = '0;
            ram_req.wr_data     = item_ff;
            res_in.status       = ST_INSERTED;
            res_in.where_placed = '0;
            res_in.entry_total  = count_ff;
            state_in            = S_DONE;
         end
         S_READ_WAIT: begin
            res_in.status       = ST_READ_OK;
            res_in.read_key     = rd_data.key;
            res_in.read_payload = rd_data.payload;
            state_in            = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

// ----- hw/rtl/max_heap_insert_engine.sv -----
// Binary max-heap of up to 1024 entries, each a signed 16-bit key with a 16-bit
// payload, held in one single-port-read, single-port-write RAM with a registered
// read. Sift-up compares and moves one parent per cycle through the RAM read
// port. An insert into a non-empty heap fetches the parent of the new slot and
// climbs one level for each parent with a smaller key (at most 10 levels),
// then writes the item. An insert into an empty heap writes the root at once;
// a full-heap insert and a read of an unoccupied slot answer without the RAM;
// a read of an occupied slot waits for the RAM read. One request is worked on
// at a time. The result sits in an output register, so the next request is
// taken while the previous result waits for rsp_ready. No clearing pass is
// needed after reset.
module max_heap_insert_engine
   import mhi_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_type,
   input  logic signed [KEY_BITS-1:0] req_key,
   input  logic [PAYLOAD_BITS-1:0]    req_payload,
   input  logic [SLOT_BITS-1:0]       req_slot,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_BITS-1:0]     rsp_status,
   output logic [SLOT_BITS-1:0]       rsp_where_placed,
   output logic [COUNT_BITS-1:0]      rsp_entry_total,
   output logic signed [KEY_BITS-1:0] rsp_read_key,
   output logic [PAYLOAD_BITS-1:0]    rsp_read_payload
);

   mhi_ram_req_type ram_req;
   mhi_entry_type   rd_data;
   mhi_result_type  result;
   logic            res_valid;
   logic            res_take;
   logic            rsp_valid_ff, rsp_valid_in;
   mhi_result_type  rsp_ff, rsp_in;

   mhi_entry_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   mhi_sift_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_key     (req_key),
      .req_payload (req_payload),
      .req_slot    (req_slot),
      .ram_req     (ram_req),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .result      (result)
   );

   // The output register takes a new beat when empty or draining this cycle.
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_where_placed = rsp_ff.where_placed;
   assign rsp_entry_total  = rsp_ff.entry_total;
   assign rsp_read_key     = rsp_ff.read_key;
   assign rsp_read_payload = rsp_ff.read_payload;

endmodule

// ----- tb/tb.sv -----
module tb
   import mhi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PRINT_CAP = 50;

   typedef struct {
      logic                       kind;
      logic signed [KEY_BITS-1:0] key;
      logic [PAYLOAD_BITS-1:0]    payload;
      logic [SLOT_BITS-1:0]       slot;
   } heap_request_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = REQ_INSERT;
   logic signed [KEY_BITS-1:0] req_key = '0;
   logic [PAYLOAD_BITS-1:0]    req_payload = '0;
   logic [SLOT_BITS-1:0]       req_slot = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]     rsp_status;
   logic [SLOT_BITS-1:0]       rsp_where_placed;
   logic [COUNT_BITS-1:0]      rsp_entry_total;
   logic signed [KEY_BITS-1:0] rsp_read_key;
   logic [PAYLOAD_BITS-1:0]    rsp_read_payload;

   heap_request_type request_backlog[$];
   mhi_result_type   expected_heap_results[$];

   // Shadow copy of the heap, updated as requests are taken.
   logic signed [KEY_BITS-1:0] heap_key_shadow[CAPACITY];
   logic [PAYLOAD_BITS-1:0]    heap_payload_shadow[CAPACITY];
   int                         held_count = 0;

   int planned_count = 0;
   int requests_queued = 0;
   int requests_taken = 0;
   int rsp_beats = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   max_heap_insert_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_payload      (req_payload),
      .req_slot         (req_slot),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_where_placed (rsp_where_placed),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_read_key     (rsp_read_key),
      .rsp_read_payload (rsp_read_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic mhi_result_type heap_apply(input heap_request_type r);
      mhi_result_type             res;
      int                         pos;
      int                         up;
      logic signed [KEY_BITS-1:0] tk;
      logic [PAYLOAD_BITS-1:0]    tp;
      res = '0;
      if (r.kind == REQ_INSERT) begin
         if (held_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            pos = held_count;
            heap_key_shadow[pos] = r.key;
            heap_payload_shadow[pos] = r.payload;
            // Climb only while strictly greater, so equal keys stay below.
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(heap_key_shadow[pos] > heap_key_shadow[up])) break;
               tk = heap_key_shadow[pos];
               tp = heap_payload_shadow[pos];
               heap_key_shadow[pos] = heap_key_shadow[up];
               heap_payload_shadow[pos] = heap_payload_shadow[up];
               heap_key_shadow[up] = tk;
               heap_payload_shadow[up] = tp;
               pos = up;
            end
            held_count++;
            res.status = ST_INSERTED;
            res.where_placed = SLOT_BITS'(pos);
         end
      end else begin
         res.where_placed = r.slot;
         if (int'(r.slot) < held_count) begin
            res.status = ST_READ_OK;
            res.read_key = heap_key_shadow[r.slot];
            res.read_payload = heap_payload_shadow[r.slot];
         end else begin
            res.status = ST_READ_EMPTY;
         end
      end
      res.entry_total = COUNT_BITS'(held_count);
      return res;
   endfunction

   task automatic push_request(input logic kind, input logic signed [KEY_BITS-1:0] key,
                               input logic [PAYLOAD_BITS-1:0] payload,
                               input logic [SLOT_BITS-1:0] slot);
      heap_request_type r;
      r.kind = kind;
      r.key = key;
      r.payload = payload;
      r.slot = slot;
      request_backlog.push_back(r);
      requests_queued++;
      if (kind == REQ_INSERT && planned_count < CAPACITY) planned_count++;
   endtask

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP)
         $display("[%0t] rsp beat %0d: %s", $realtime, rsp_beats, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   // Driver: bursts of back-to-back beats separated by random gaps.
   always @(posedge clock) begin
      heap_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 30);
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            nxt = request_backlog.pop_front();
            req_valid <= 1'b1;
            req_type <= nxt.kind;
            req_key <= nxt.key;
            req_payload <= nxt.payload;
            req_slot <= nxt.slot;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // Receiver: switches between always ready, coin flip, mostly stalled and periodic.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 5) == 0);
            default: rsp_ready <= (cycle_count % 5 == 0);
         endcase
      end
   end

   // Monitor: predicts on each request beat, checks each result beat in order.
   always @(posedge clock) begin
      mhi_result_type   want;
      heap_request_type taken;
      if (!reset) begin
         if (req_valid && req_ready) begin
            taken.kind = req_type;
            taken.key = req_key;
            taken.payload = req_payload;
            taken.slot = req_slot;
            expected_heap_results.push_back(heap_apply(taken));
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_heap_results.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = expected_heap_results.pop_front();
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("where_placed", 32'(rsp_where_placed), 32'(want.where_placed));
               check_field("entry_total", 32'(rsp_entry_total), 32'(want.entry_total));
               check_field("read_key", 32'(rsp_read_key), 32'(want.read_key));
               check_field("read_payload", 32'(rsp_read_payload), 32'(want.read_payload));
            end
            rsp_beats++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         report_mismatch($sformatf("timeout with %0d results outstanding",
                                   expected_heap_results.size()));
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int                         n;
      int                         rising_key;
      logic                       kind;
      logic signed [KEY_BITS-1:0] k;
      logic [SLOT_BITS-1:0]       s;

      // Reads on an empty heap, then the key extremes and equal keys.
      push_request(REQ_READ, 16'sh7fff, 16'hffff, 10'd0);
      push_request(REQ_READ, -16'sd1, 16'h0000, 10'h3ff);
      push_request(REQ_INSERT, 16'sd0, 16'h0000, 10'h3ff);
      push_request(REQ_INSERT, -16'sd32768, 16'hffff, 10'd0);
      push_request(REQ_INSERT, 16'sd32767, 16'h1234, 10'h155);
      push_request(REQ_INSERT, 16'sd32767, 16'h5555, 10'h2aa);
      push_request(REQ_INSERT, -16'sd1, 16'ha5a5, 10'd0);
      push_request(REQ_INSERT, -16'sd1, 16'h5a5a, 10'd0);
      for (int i = 0; i < 6; i++) push_request(REQ_READ, 16'sd0, 16'h0000, SLOT_BITS'(i));
      push_request(REQ_READ, 16'sd0, 16'h0000, 10'd6);
      push_request(REQ_READ, 16'sd0, 16'h0000, 10'h3ff);
      push_request(REQ_INSERT, 16'sd1, 16'h8001, 10'd0);
      push_request(REQ_INSERT, -16'sd32768, 16'h0001, 10'd0);
      push_request(REQ_READ, 16'sd0, 16'h0000, 10'd7);
      push_request(REQ_READ, 16'sd0, 16'h0000, 10'd8);

      // Random part: mostly inserts, with reads of occupied and free slots.
      n = 0;
      rising_key = -32768;
      while (n < 900) begin
         if (planned_count < CAPACITY)
            kind = ($urandom_range(0, 99) < 85) ? REQ_INSERT : REQ_READ;
         else
            kind = $urandom_range(0, 1) ? REQ_INSERT : REQ_READ;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = KEY_BITS'($urandom);
            5, 6: begin
               k = KEY_BITS'($urandom_range(0, 8));
               k = k - 16'sd4;
            end
            7, 8: begin
               // Rising keys climb far, often to the root.
               if (rising_key > 32500) rising_key = int'($urandom_range(0, 2000)) - 32768;
               rising_key = rising_key + int'($urandom_range(1, 200));
               k = KEY_BITS'(rising_key);
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: k = -16'sd32768;
                  1: k = 16'sd32767;
                  2: k = 16'sd0;
                  default: k = -16'sd1;
               endcase
            end
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: s = (planned_count > 0) ?
                                  SLOT_BITS'($urandom_range(0, planned_count - 1)) : 10'd0;
            6, 7: s = (planned_count < CAPACITY) ? SLOT_BITS'(planned_count) : 10'h3ff;
            default: s = SLOT_BITS'($urandom);
         endcase
         push_request(kind, k, PAYLOAD_BITS'($urandom), s);
         n++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < requests_queued || expected_heap_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mhi_pkg.sv
hw/rtl/mhi_entry_ram.sv
hw/rtl/mhi_sift_ctrl.sv
hw/rtl/max_heap_insert_engine.sv
tb/tb.sv
